### hw/rtl/base64_codec_top_assert.svh
// assertion macros for the base64 codec
// used by base64_codec_top, which supplies i_clk and i_rst_n
`ifndef BASE64_CODEC_TOP_ASSERT_SVH
`define BASE64_CODEC_TOP_ASSERT_SVH

// checked only outside reset
`define B64C_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define B64C_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/b64c_pkg.sv
`timescale 1ns / 1ps
// shared types, character constants and alphabet mapping for the base64 codec
// no dependencies
package b64c_pkg;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       error;
    } t_out;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam int unsigned RES_SLOTS = 4;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return w + 8'h41;
        else if (v < 6'd52) return w + 8'h47;   // 'a' - 26
        else if (v < 6'd62) return w - 8'h04;   // '0' - 52
        else if (v == 6'd62) return 8'h2B;
        else                return 8'h2F;
    endfunction

    // alphabet character to sextet, anything else to zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] w;
        w = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A)      w = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A) w = c - 8'h47;
        else if (c >= 8'h30 && c <= 8'h39) w = c + 8'h04;
        else if (c == 8'h2B)               w = 8'd62;
        else if (c == 8'h2F)               w = 8'd63;
        return w[5:0];
    endfunction

endpackage

### hw/rtl/base64_codec_top.sv
`timescale 1ns / 1ps
// base64 codec: an input transaction is first held in an input register, then its
// results load a four-slot result queue, drained one per cycle while i_out_ready is high
// throughput: one item per cycle while items give at most one result and i_out_ready
// stays high, else set by the single result port (an encode group of three bytes gives four results)
// synchronous active-low reset clears direction, codec state and queue
// depends on b64c_pkg and base64_codec_top_assert.svh
`include "base64_codec_top_assert.svh"

module base64_codec_top
    import b64c_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic        r_dir;

    logic        r_in_valid;
    t_in         r_in;

    logic [15:0] r_held, n_held;
    logic [1:0]  r_bc, n_bc;
    logic [17:0] r_accum, n_accum;
    logic [1:0]  r_sc, n_sc;
    logic        r_third, n_third;
    logic [23:0] r_pend, n_pend;
    logic        r_pv, n_pv;
    logic [1:0]  r_pads, n_pads;

    t_out        r_slot [RES_SLOTS];
    logic [2:0]  r_cnt;

    t_out        res [RES_SLOTS];
    logic [2:0]  res_n;

    logic        pop;
    logic        advance;

    assign pop        = o_out_valid && i_out_ready;
    assign advance    = r_in_valid && ((r_cnt == 3'd0) || (r_cnt == 3'd1 && pop));
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_slot[0];

    // result generation for the registered item
    always_comb begin
        logic [23:0] g;
        logic [5:0]  sx;
        logic        is_pad;
        logic        do_fin;
        logic [23:0] fin_g;
        logic [1:0]  fin_p;
        logic [2:0]  k;

        n_held  = r_held;
        n_bc    = r_bc;
        n_accum = r_accum;
        n_sc    = r_sc;
        n_third = r_third;
        n_pend  = r_pend;
        n_pv    = r_pv;
        n_pads  = r_pads;
        for (int i = 0; i < RES_SLOTS; i++) begin
            res[i] = '0;
        end
        g      = '0;
        sx     = sextet_of(r_in.data_in);
        is_pad = (r_in.data_in == CHAR_PAD);
        do_fin = 1'b0;
        fin_g  = '0;
        fin_p  = '0;
        k      = 3'd0;

        if (r_dir == DIR_ENCODE) begin
            if (r_bc == 2'd2) begin
                g = {r_held, r_in.data_in};
                res[0].data_out = enc_char(g[23:18]);
                res[1].data_out = enc_char(g[17:12]);
                res[2].data_out = enc_char(g[11:6]);
                res[3].data_out = enc_char(g[5:0]);
                res[3].last_out = r_in.last_in;
                k       = 3'd4;
                n_held  = '0;
                n_bc    = 2'd0;
            end else begin
                n_held = {r_held[7:0], r_in.data_in};
                n_bc   = r_bc + 2'd1;
                if (r_in.last_in) begin
                    if (r_bc == 2'd0) g = {r_in.data_in, 16'h0000};
                    else              g = {r_held[7:0], r_in.data_in, 8'h00};
                    res[0].data_out = enc_char(g[23:18]);
                    res[1].data_out = enc_char(g[17:12]);
                    res[2].data_out = (r_bc == 2'd1) ? enc_char(g[11:6]) : CHAR_PAD;
                    res[3].data_out = CHAR_PAD;
                    res[3].last_out = 1'b1;
                    k      = 3'd4;
                    n_held = '0;
                    n_bc   = 2'd0;
                end
            end
        end else begin
            if (r_in.data_in == CHAR_CR || r_in.data_in == CHAR_LF) begin
                if (r_in.last_in) begin
                    if (r_sc == 2'd0 && r_pv) begin
                        do_fin = 1'b1;
                        fin_g  = r_pend;
                        fin_p  = r_pads;
                    end else begin
                        res[0].last_out = 1'b1;
                        res[0].error    = 1'b1;
                        k = 3'd1;
                    end
                    n_accum = '0; n_sc = '0; n_third = 1'b0;
                    n_pend  = '0; n_pv = 1'b0; n_pads  = '0;
                end
            end else begin
                if (r_pv) begin
                    // a later character shows the held group was not final
                    res[0].data_out = r_pend[23:16];
                    res[1].data_out = r_pend[15:8];
                    res[2].data_out = r_pend[7:0];
                    k      = 3'd3;
                    n_pv   = 1'b0;
                    n_pend = '0;
                    n_pads = '0;
                end
                if (r_sc != 2'd3) begin
                    if (r_sc == 2'd2) n_third = is_pad;
                    n_accum = {r_accum[11:0], sx};
                    n_sc    = r_sc + 2'd1;
                    if (r_in.last_in) begin
                        res[k[1:0]].data_out = 8'h00;
                        res[k[1:0]].last_out = 1'b1;
                        res[k[1:0]].error    = 1'b1;
                        k = k + 3'd1;
                        n_accum = '0; n_sc = '0; n_third = 1'b0;
                        n_pend  = '0; n_pv = 1'b0; n_pads  = '0;
                    end
                end else begin
                    g       = {r_accum, sx};
                    n_accum = '0;
                    n_sc    = 2'd0;
                    n_third = 1'b0;
                    if (r_in.last_in) begin
                        do_fin = 1'b1;
                        fin_g  = g;
                        fin_p  = {r_third, is_pad};
                        n_pend = '0; n_pv = 1'b0; n_pads = '0;
                    end else begin
                        n_pend = g;
                        n_pads = {r_third, is_pad};
                        n_pv   = 1'b1;
                    end
                end
            end
        end

        // final group, trimmed by its pad flags
        if (do_fin) begin
            res[k[1:0]].data_out = fin_g[23:16];
            res[k[1:0]].last_out = (fin_p == 2'b11);
            k = k + 3'd1;
            if (!fin_p[1]) begin
                res[k[1:0]].data_out = fin_g[15:8];
                res[k[1:0]].last_out = fin_p[0];
                k = k + 3'd1;
            end
            if (!fin_p[0]) begin
                res[k[1:0]].data_out = fin_g[7:0];
                res[k[1:0]].last_out = 1'b1;
                k = k + 3'd1;
            end
        end
        res_n = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
        end else if (i_cfg_wr_en) begin
            r_dir <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_bc    <= '0;
            r_accum <= '0;
            r_sc    <= '0;
            r_third <= 1'b0;
            r_pend  <= '0;
            r_pv    <= 1'b0;
            r_pads  <= '0;
        end else if (advance) begin
            r_held  <= n_held;
            r_bc    <= n_bc;
            r_accum <= n_accum;
            r_sc    <= n_sc;
            r_third <= n_third;
            r_pend  <= n_pend;
            r_pv    <= n_pv;
            r_pads  <= n_pads;
        end
    end

    // result queue: head in slot 0, shifts on each output transaction unless a new item's results load it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (advance) begin
            r_cnt <= res_n;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < RES_SLOTS; i++) begin
                r_slot[i] <= res[i];
            end
        end else if (pop) begin
            for (int i = 0; i < RES_SLOTS - 1; i++) begin
                r_slot[i] <= r_slot[i + 1];
            end
        end
    end

    `B64C_ASSERT_ALWAYS(a_reset_clears, (!i_rst_n) |=> (!o_out_valid && o_in_ready), "not idle after reset")
    `B64C_ASSERT(a_cnt_range, r_cnt <= 3'd4, "result queue count out of range")
    `B64C_ASSERT(a_pend_vs_sc, !(r_pv && r_sc == 2'd3), "held group alongside a full sextet group")
    `B64C_ASSERT(a_err_form, (o_out_valid && o_out_data.error) |-> (o_out_data.last_out && o_out_data.data_out == 8'h00), "malformed error result")
    `B64C_ASSERT(a_load_shows, (advance && res_n != 3'd0) |=> (o_out_valid && r_cnt == $past(res_n)), "loaded results not presented")

endmodule
